@@ design/pfmmn_pkg.sv @@
package pfmmn_pkg;

    // width of the output range registers
    localparam int CFG_W = 16;

    // quotient bits: the quotient never exceeds out_high - out_low
    localparam int QUOT_W = CFG_W;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HIGH = 1'b1;

    localparam logic ACT_OBSERVE   = 1'b0;
    localparam logic ACT_NORMALIZE = 1'b1;

    localparam logic [1:0] STAT_OBSERVED   = 2'd0;
    localparam logic [1:0] STAT_NORMALIZED = 2'd1;
    localparam logic [1:0] STAT_BAD_RANGE  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

endpackage

@@ design/pfmmn_ram.sv @@
module pfmmn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/pfmmn_div.sv @@
module pfmmn_div #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_start,
    input  logic [SAMPLE_WIDTH+pfmmn_pkg::QUOT_W-1:0]    i_num,
    input  logic [SAMPLE_WIDTH-1:0]                      i_den,
    output logic                                         o_done,
    output logic [pfmmn_pkg::QUOT_W-1:0]                 o_quot
);

    localparam int QW = pfmmn_pkg::QUOT_W;
    localparam int SW = SAMPLE_WIDTH;
    localparam int NW = SW + QW;
    localparam int CW = $clog2(QW);

    logic [SW-1:0] r_rem;
    logic [SW-1:0] r_den;
    // numerator bits shift out at the top, quotient bits shift in at the bottom
    logic [QW-1:0] r_sh;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [SW:0]   w_trial;
    logic [SW:0]   w_diff;
    logic          w_qbit;

    assign w_trial = {r_rem, r_sh[QW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_qbit  = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // upper part is below the divisor since the quotient fits QW bits
            r_rem <= i_num[NW-1:QW];
            r_sh  <= i_num[QW-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_qbit ? w_diff[SW-1:0] : w_trial[SW-1:0];
            r_sh  <= {r_sh[QW-2:0], w_qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sh;

endmodule

@@ design/per_feature_minmax_normalizer_top.sv @@
// observe, invalid range and clamped items: the result is registered in S_EVAL and shown in S_OUT,
// and the next item is accepted only once the result is taken and the sequencer is back in S_IDLE
// in-range normalize items with a nonzero span pass S_EVAL, S_MUL and S_DIV before S_OUT; S_DIV waits on
// the radix-2 restoring divider that retires one quotient bit per cycle (16 bits)
// synchronous active-low reset clears the sequencer, the per-feature valid bits (all features
// read back as min = largest sample, max = smallest sample) and sets out_low 0, out_high 32767
module per_feature_minmax_normalizer_top #(
    parameter int NUM_FEATURES = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_action,
    input  logic [3:0]                            i_feature,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_sample,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [SAMPLE_WIDTH-1:0]        o_value,
    output logic [1:0]                            o_status,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pfmmn_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pfmmn_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int QW = pfmmn_pkg::QUOT_W;
    localparam int NW = SW + QW;
    localparam int FW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int EW = (SW > pfmmn_pkg::CFG_W) ? SW : pfmmn_pkg::CFG_W;
    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

    pfmmn_pkg::t_state r_state, n_state;

    logic                           r_action, n_action;
    logic [3:0]                     r_feat, n_feat;
    logic signed [SW-1:0]           r_sample, n_sample;
    logic [SW-1:0]                  r_diff, n_diff;
    logic [SW-1:0]                  r_span, n_span;
    logic [pfmmn_pkg::CFG_W-1:0]    r_rng, n_rng;
    logic signed [SW-1:0]           r_value, n_value;
    logic [1:0]                     r_status, n_status;
    logic signed [pfmmn_pkg::CFG_W-1:0] r_out_low;
    logic signed [pfmmn_pkg::CFG_W-1:0] r_out_high;
    logic [NUM_FEATURES-1:0]        r_vld;

    logic [FW-1:0]                  w_addr;
    logic [2*SW-1:0]                w_rdata;
    logic                           w_in_range;
    logic                           w_known;
    logic signed [SW-1:0]           w_lo;
    logic signed [SW-1:0]           w_hi;
    logic signed [SW-1:0]           w_new_lo;
    logic signed [SW-1:0]           w_new_hi;
    logic                           w_we;
    logic signed [EW-1:0]           w_ol_ext;
    logic signed [EW-1:0]           w_oh_ext;
    logic [EW-1:0]                  w_sum;
    logic [NW-1:0]                  w_prod;
    logic                           w_div_start;
    logic                           w_div_done;
    logic [QW-1:0]                  w_quot;

    assign w_addr     = FW'(r_feat);
    assign w_in_range = (32'(r_feat) < NUM_FEATURES);
    assign w_known    = w_in_range && r_vld[w_addr];
    // a feature never observed reads as an empty range
    assign w_lo       = w_known ? w_rdata[SW-1:0]    : SMAX;
    assign w_hi       = w_known ? w_rdata[2*SW-1:SW] : SMIN;
    assign w_new_lo   = (r_sample < w_lo) ? r_sample : w_lo;
    assign w_new_hi   = (r_sample > w_hi) ? r_sample : w_hi;

    assign w_ol_ext   = EW'(r_out_low);
    assign w_oh_ext   = EW'(r_out_high);
    assign w_sum      = w_ol_ext + EW'(w_quot);
    assign w_prod     = NW'(r_diff) * NW'(r_rng);

    pfmmn_ram #(
        .WIDTH (2 * SW),
        .DEPTH (NUM_FEATURES)
    ) u_minmax_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata ({w_new_hi, w_new_lo}),
        .i_raddr (FW'(i_feature)),
        .o_rdata (w_rdata)
    );

    pfmmn_div #(
        .SAMPLE_WIDTH (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod),
        .i_den   (r_span),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfmmn_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_feat      = r_feat;
        n_sample    = r_sample;
        n_diff      = r_diff;
        n_span      = r_span;
        n_rng       = r_rng;
        n_value     = r_value;
        n_status    = r_status;
        w_we        = 1'b0;
        w_div_start = 1'b0;
        o_ready     = 1'b0;
        o_valid     = 1'b0;
        case (r_state)
            pfmmn_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_action = i_action;
                    n_feat   = i_feature;
                    n_sample = i_sample;
                    n_state  = pfmmn_pkg::S_EVAL;
                end
            end
            pfmmn_pkg::S_EVAL: begin
                n_value = r_sample;
                n_state = pfmmn_pkg::S_OUT;
                if (r_action == pfmmn_pkg::ACT_OBSERVE) begin
                    n_status = pfmmn_pkg::STAT_OBSERVED;
                    w_we     = w_in_range;
                end else if (r_out_high <= r_out_low) begin
                    n_status = pfmmn_pkg::STAT_BAD_RANGE;
                end else begin
                    n_status = pfmmn_pkg::STAT_NORMALIZED;
                    n_diff   = r_sample - w_lo;
                    n_span   = w_hi - w_lo;
                    n_rng    = r_out_high - r_out_low;
                    if (r_sample < w_lo) begin
                        n_value = w_ol_ext[SW-1:0];
                    end else if (r_sample > w_hi) begin
                        n_value = w_oh_ext[SW-1:0];
                    end else if (w_hi == w_lo) begin
                        n_value = w_ol_ext[SW-1:0];
                    end else begin
                        n_state = pfmmn_pkg::S_MUL;
                    end
                end
            end
            pfmmn_pkg::S_MUL: begin
                // product goes straight into the divider registers
                w_div_start = 1'b1;
                n_state     = pfmmn_pkg::S_DIV;
            end
            pfmmn_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_value = w_sum[SW-1:0];
                    n_state = pfmmn_pkg::S_OUT;
                end
            end
            pfmmn_pkg::S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = pfmmn_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfmmn_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_feat   <= n_feat;
        r_sample <= n_sample;
        r_diff   <= n_diff;
        r_span   <= n_span;
        r_rng    <= n_rng;
        r_value  <= n_value;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_we) begin
            r_vld[w_addr] <= 1'b1;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_low  <= '0;
            r_out_high <= {1'b0, {(pfmmn_pkg::CFG_W-1){1'b1}}};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pfmmn_pkg::CFG_OUT_LOW:  r_out_low  <= i_cfg_data;
                pfmmn_pkg::CFG_OUT_HIGH: r_out_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_value  = r_value;
    assign o_status = r_status;

endmodule
